// ----- rtl/pds_pkg.sv -----
// Shared types, constants and helper functions for the periodic dispatch scheduler.
package pds_pkg;

   localparam int MAX_CLIENTS = 64;
   localparam int ID_BITS     = 16;
   localparam int TIME_BITS   = 48;
   localparam int PERIOD_BITS = 16;
   localparam int SLOT_BITS   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int COUNT_BITS  = $clog2(MAX_CLIENTS + 1);

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_POP    = 2'd2
   } cmd_type;

   // One client. The slot records the order of adding and breaks ties of
   // equal due time and equal id.
   typedef struct packed {
      logic [TIME_BITS-1:0]   due;
      logic [ID_BITS-1:0]     id;
      logic [SLOT_BITS-1:0]   slot;
      logic [PERIOD_BITS-1:0] period;
   } entry_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      cmd_type   cmd;
      entry_type new_entry;
   } cell_ctl_type;

   // True when a is served before b.
   function automatic logic entry_before(entry_type a, entry_type b);
      logic before_q;
      before_q = {a.due, a.id, a.slot} < {b.due, b.id, b.slot};
      return before_q;
   endfunction

   // Due time plus period, saturating at the largest due time.
   function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] due,
                                                    logic [PERIOD_BITS-1:0] period);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, due} + (TIME_BITS + 1)'(period);
      return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   endfunction

endpackage

// ----- rtl/pds_cell.sv -----
// One cell of the sorted client chain: holds a client and shifts or takes an insert.
module pds_cell (
   input  logic                  clock,
   input  pds_pkg::cell_ctl_type ctl,
   input  logic                  occupied,
   input  pds_pkg::entry_type    left_entry,
   input  logic                  left_less,
   input  pds_pkg::entry_type    right_entry,
   output pds_pkg::entry_type    entry_q,
   output logic                  less
);

   pds_pkg::entry_type entry_ff;
   pds_pkg::entry_type entry_in;

   // An empty cell sorts after everything, so the new client lands in the first
   // cell whose own client comes later; every cell past that one takes its left
   // neighbor's client.
   always_comb begin
      less     = ~occupied | pds_pkg::entry_before(ctl.new_entry, entry_ff);
      entry_in = entry_ff;
      unique case (ctl.cmd)
         pds_pkg::CMD_INSERT: begin
            if (less) begin
               entry_in = left_less ? left_entry : ctl.new_entry;
            end
         end
         pds_pkg::CMD_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

// ----- rtl/periodic_dispatch_scheduler_core.sv -----
// Top level of the periodic dispatch scheduler: controller, result register and cell chain.
//
// Clients are kept in a chain of MAX_CLIENTS cells sorted by due time, then id,
// then order of adding, so the next client to serve always sits in the first
// cell. An add, a clear, an unused operation or a dispatch on an empty table
// is handled in ST_IDLE alone; a dispatch that finds a client goes on to
// ST_REINSERT: first the head client is reported and the chain shifts toward
// the head, then the client is put back one period later, every cell comparing
// it against its own client in parallel. Each item gives one result transfer,
// held in an output register; a new item is taken once the previous result has
// left or is leaving and ST_REINSERT is over. Due times saturate at their maximum.
module periodic_dispatch_scheduler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_client_id,
   input  logic [15:0] req_period,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_chosen_id,
   output logic [47:0] rsp_due_time
);

   typedef enum logic {
      ST_IDLE,
      ST_REINSERT
   } state_type;

   state_type                           state_ff, state_in;
   logic [pds_pkg::COUNT_BITS-1:0]      count_ff, count_in;
   pds_pkg::entry_type                  reinsert_ff, reinsert_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [1:0]                          rsp_status_ff, rsp_status_in;
   logic [15:0]                         rsp_chosen_id_ff, rsp_chosen_id_in;
   logic [47:0]                         rsp_due_time_ff, rsp_due_time_in;

   logic                                req_accept;
   logic [pds_pkg::COUNT_BITS-1:0]      fill;
   pds_pkg::cell_ctl_type               ctl;
   pds_pkg::entry_type                  add_entry;
   pds_pkg::entry_type                  head;
   pds_pkg::entry_type                  cell_entry [pds_pkg::MAX_CLIENTS];
   logic [pds_pkg::MAX_CLIENTS-1:0]     cell_less;
   logic [pds_pkg::MAX_CLIENTS-1:0]     cell_occupied;

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign head       = cell_entry[0];

   // While a dispatched client is out of the chain, one cell fewer is in use.
   assign fill = (state_ff == ST_REINSERT) ? count_ff - 1'b1 : count_ff;

   always_comb begin
      add_entry.due    = pds_pkg::TIME_BITS'(req_period);
      add_entry.id     = pds_pkg::ID_BITS'(req_client_id);
      add_entry.slot   = pds_pkg::SLOT_BITS'(count_ff);
      add_entry.period = req_period;
   end

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      reinsert_in      = reinsert_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_status_in    = rsp_status_ff;
      rsp_chosen_id_in = rsp_chosen_id_ff;
      rsp_due_time_in  = rsp_due_time_ff;
      ctl.cmd          = pds_pkg::CMD_HOLD;
      ctl.new_entry    = add_entry;

      if (state_ff == ST_REINSERT) begin
         ctl.cmd       = pds_pkg::CMD_INSERT;
         ctl.new_entry = reinsert_ff;
         state_in      = ST_IDLE;
      end else if (req_accept) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = pds_pkg::STATUS_OK;
         rsp_chosen_id_in = '0;
         rsp_due_time_in  = '0;
         unique case (pds_pkg::op_type'(req_operation))
            pds_pkg::OP_ADD: begin
               if (count_ff == pds_pkg::COUNT_BITS'(pds_pkg::MAX_CLIENTS)) begin
                  rsp_status_in = pds_pkg::STATUS_FULL;
               end else begin
                  ctl.cmd  = pds_pkg::CMD_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            pds_pkg::OP_DISPATCH: begin
               if (count_ff == '0) begin
                  rsp_status_in = pds_pkg::STATUS_EMPTY;
               end else begin
                  rsp_chosen_id_in = 16'(head.id);
                  rsp_due_time_in  = 48'(head.due);
                  reinsert_in      = head;
                  reinsert_in.due  = pds_pkg::sat_add(head.due, head.period);
                  ctl.cmd          = pds_pkg::CMD_POP;
                  state_in         = ST_REINSERT;
               end
            end
            pds_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               rsp_status_in = pds_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      reinsert_ff      <= reinsert_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_chosen_id_ff <= rsp_chosen_id_in;
      rsp_due_time_ff  <= rsp_due_time_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_chosen_id = rsp_chosen_id_ff;
   assign rsp_due_time  = rsp_due_time_ff;

   for (genvar i = 0; i < pds_pkg::MAX_CLIENTS; i++) begin : g_cell
      pds_pkg::entry_type left_entry;
      pds_pkg::entry_type right_entry;
      logic               left_less;

      assign cell_occupied[i] = fill > pds_pkg::COUNT_BITS'(i);

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_less  = 1'b0;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_less  = cell_less[i-1];
      end

      if (i == pds_pkg::MAX_CLIENTS - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      pds_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (cell_occupied[i]),
         .left_entry  (left_entry),
         .left_less   (left_less),
         .right_entry (right_entry),
         .entry_q     (cell_entry[i]),
         .less        (cell_less[i])
      );
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pds_pkg::COUNT_BITS'(pds_pkg::MAX_CLIENTS))
      else $error("client count exceeds table size");

   a_reinsert_after_dispatch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REINSERT) |->
         $past(req_accept && req_operation == pds_pkg::OP_DISPATCH && count_ff != '0))
      else $error("reinsert phase without a dispatch");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && count_ff >= pds_pkg::COUNT_BITS'(2)) |->
         !pds_pkg::entry_before(cell_entry[1], cell_entry[0]))
      else $error("chain head is not the earliest client");
`endif

endmodule
